### rtl/qrs_pkg.sv
package qrs_pkg;

  localparam int CoefW   = 16;
  localparam int ValW    = 32;
  localparam int SqSteps = 32;   // one root bit per stage
  localparam int DivSteps = 33;  // one quotient bit per stage
  localparam int SqLimit = 20;   // square test covers 1..SqLimit-1

  typedef struct packed {
    logic                     vld;
    logic signed [CoefW-1:0]  a;
    logic signed [31:0]       nb;     // -b * 2^15
    logic                     cplx;
    logic                     exact;
    logic [35:0]              rem;
    logic [31:0]              root;
    logic [63:0]              rad;
  } sq_t;

  typedef struct packed {
    logic [32:0] n;    // dividend shifting out, quotient shifting in
    logic [15:0] rem;
  } dlane_t;

  typedef struct packed {
    logic        vld;
    logic        a_zero;
    logic [15:0] dvs;
    logic        neg1;
    logic        neg2;
    logic        cplx;
    logic        exact;
    dlane_t      l1;
    dlane_t      l2;
  } dv_t;

  // true when hi equals i*i for some i in 1..SqLimit-1
  function automatic logic is_small_square(logic [16:0] hi);
    logic hit;
    hit = 1'b0;
    for (int i = 1; i < SqLimit; i++) begin
      if (hi == 17'(i * i)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

### rtl/quadratic_root_solver.sv
// Quadratic root solver: roots of a*x^2 + b*x + c.
//
// Input channel s_*: one transaction carries a, b, c in signed Q8.8.
// Output channel m_*: one transaction per input with both roots in signed
// Q16.16 (or real and imaginary part when the discriminant is negative)
// plus four status flags in m_tuser.
//
// Pipeline: 69 register stages (product stage, discriminant stage,
// 32 square-root stages, numerator stage, 33 divider stages, output
// register). Throughput: one transaction per cycle while m_tready does
// not hold the pipe; the square-root and divider chains resolve one
// bit per stage.
//
// Reset clears every stage valid bit and m_tvalid; data registers are
// not reset. When the receiver holds m_tready low with a result waiting,
// the whole pipeline freezes and s_tready drops; nothing is lost or
// repeated, and the pipe moves again as soon as m_tready returns.
module quadratic_root_solver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // coef_a[15:0], coef_b[31:16], coef_c[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // value_one[31:0], value_two[63:32]
  output logic [3:0]  m_tuser    // roots_complex, exact_square, no_quadratic, saturated
);
  import qrs_pkg::*;

  // global advance: the output register is empty or being drained
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---- stage 1: products ----
  logic                    p1_vld;
  logic signed [CoefW-1:0] p1_a;
  logic signed [CoefW-1:0] p1_b;
  logic signed [31:0]      p1_bb;
  logic signed [31:0]      p1_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= s_tvalid;
    end
    if (en) begin
      p1_a  <= s_tdata[15:0];
      p1_b  <= s_tdata[31:16];
      p1_bb <= $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
      p1_ac <= $signed(s_tdata[15:0]) * $signed(s_tdata[47:32]);
    end
  end

  // ---- stage 2: discriminant, magnitude, square test ----
  logic signed [33:0] disc;
  logic [32:0]        mag;
  logic               d_neg;
  sq_t                sq_r [0:SqSteps];

  assign disc  = 34'(p1_bb) - (34'(p1_ac) <<< 2);
  assign d_neg = disc[33];
  assign mag   = d_neg ? 33'(-disc) : disc[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_r[0].vld <= 1'b0;
    end else if (en) begin
      sq_r[0].vld <= p1_vld;
    end
    if (en) begin
      sq_r[0].a     <= p1_a;
      sq_r[0].nb    <= -(32'(p1_b) <<< 15);
      sq_r[0].cplx  <= d_neg;
      sq_r[0].exact <= d_neg && (mag[15:0] == 16'd0) && is_small_square(mag[32:16]);
      sq_r[0].rem   <= '0;
      sq_r[0].root  <= '0;
      sq_r[0].rad   <= {1'b0, mag, 30'd0};
    end
  end

  // ---- square-root chain: one root bit per stage ----
  function automatic sq_t sq_step(sq_t s);
    sq_t         r;
    logic [35:0] cur;
    logic [35:0] trial;
    r     = s;
    cur   = {s.rem[33:0], s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = s.rad << 2;
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_r[k+1].vld <= 1'b0;
      end else if (en) begin
        sq_r[k+1] <= sq_step(sq_r[k]);
      end
    end
  end

  // ---- numerator stage: signs and magnitudes for both dividers ----
  sq_t                sq_o;
  logic signed [33:0] nb34;
  logic signed [33:0] s34;
  logic signed [33:0] n1;
  logic signed [33:0] n2;
  dv_t                dv_r [0:DivSteps];

  assign sq_o = sq_r[SqSteps];
  assign nb34 = 34'(sq_o.nb);
  assign s34  = {2'b00, sq_o.root};
  assign n1   = sq_o.cplx ? nb34 : nb34 + s34;
  assign n2   = sq_o.cplx ? s34  : nb34 - s34;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0].a_zero <= (sq_o.a == '0);
      dv_r[0].dvs    <= sq_o.a[15] ? 16'(-sq_o.a) : 16'(sq_o.a);
      dv_r[0].neg1   <= n1[33] ^ sq_o.a[15];
      dv_r[0].neg2   <= n2[33] ^ sq_o.a[15];
      dv_r[0].cplx   <= sq_o.cplx;
      dv_r[0].exact  <= sq_o.exact;
      dv_r[0].l1.n   <= n1[33] ? 33'(-n1) : n1[32:0];
      dv_r[0].l2.n   <= n2[33] ? 33'(-n2) : n2[32:0];
      dv_r[0].l1.rem <= '0;
      dv_r[0].l2.rem <= '0;
    end
    if (rst) begin
      dv_r[0].vld <= 1'b0;
    end else if (en) begin
      dv_r[0].vld <= sq_o.vld;
    end
  end

  // ---- divider chains: one quotient bit per stage, two lanes ----
  function automatic dlane_t div_step(dlane_t l, logic [15:0] dvs);
    dlane_t      r;
    logic [16:0] cur;
    logic        qb;
    cur = {l.rem, l.n[32]};
    qb  = (cur >= {1'b0, dvs});
    r.rem = qb ? 16'(cur - {1'b0, dvs}) : cur[15:0];
    r.n   = {l.n[31:0], qb};
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t d);
    dv_t r;
    r    = d;
    r.l1 = div_step(d.l1, d.dvs);
    r.l2 = div_step(d.l2, d.dvs);
    return r;
  endfunction

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_r[j+1].vld <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_step(dv_r[j]);
      end
    end
  end

  // ---- sign, saturation, output register ----
  dv_t               dv_o;
  logic [ValW-1:0]   v1;
  logic [ValW-1:0]   v2;
  logic              sat1;
  logic              sat2;

  assign dv_o = dv_r[DivSteps];

  function automatic logic [ValW:0] apply_sign(logic [32:0] q, logic neg);
    logic [ValW-1:0] v;
    logic            s;
    s = 1'b0;
    if (neg) begin
      if (q > 33'h0_8000_0000) begin
        v = 32'h8000_0000;
        s = 1'b1;
      end else begin
        v = 32'(-q);
      end
    end else begin
      if (q > 33'h0_7FFF_FFFF) begin
        v = 32'h7FFF_FFFF;
        s = 1'b1;
      end else begin
        v = q[31:0];
      end
    end
    return {s, v};
  endfunction

  assign {sat1, v1} = apply_sign(dv_o.l1.n, dv_o.neg1);
  assign {sat2, v2} = apply_sign(dv_o.l2.n, dv_o.neg2);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_o.vld;
    end
    if (en) begin
      m_tdata    <= dv_o.a_zero ? 64'd0 : {v2, v1};
      m_tuser[0] <= dv_o.cplx;
      m_tuser[1] <= dv_o.exact;
      m_tuser[2] <= dv_o.a_zero;
      m_tuser[3] <= !dv_o.a_zero && (sat1 || sat2);
    end
  end

endmodule
